FILE: sv/grmv_pkg.sv
// ----------------------------------------------------------------------------
// grmv_pkg
// Shared types and constants for the gated running mean and variance block.
// ----------------------------------------------------------------------------
package grmv_pkg;

  localparam int DEFAULT_SLOT_COUNT = 16;
  localparam int DEFAULT_COUNT_BITS = 20;

  localparam int IN_DATA_W  = 240;
  localparam int OUT_DATA_W = 288;

  localparam int DIV_STEPS = 64;
  localparam int MUL_STEPS = 32;
  localparam int STEP_W    = 6;

  localparam logic [26:0] MISS_LIMIT    = 27'd100000000;
  localparam logic [4:0]  FILL_STATUS   = 5'd15;   // soft alarm
  localparam logic [1:0]  FILL_SEVERITY = 2'd3;    // invalid alarm

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CHECK  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_ACC,
    ST_DIV_M,
    ST_MEAN,
    ST_MUL,
    ST_VADD,
    ST_MISS,
    ST_FIN,
    ST_DIV_V,
    ST_EMIT
  } grmv_state_t;

endpackage

FILE: sv/gated_running_mean_variance.sv
// ----------------------------------------------------------------------------
// gated_running_mean_variance
// Per-slot running mean and variance sum with severity gating, repeat and
// missing-sample bookkeeping; reports a finished average on request.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transfer when           Contents
//  in_       slave      in_tvalid & in_tready   sample or check item
//  out_      master     out_tvalid & out_tready finished average of one slot
//  cfg_      write      cfg_wr_en               no_average bit
//
//  An ignored item returns to idle after evaluation. A sample that joins a
//  running average also uses the shared divider and mean update, and the
//  shift-add multiplier and sum when its product counts; a report over more
//  than one sample uses the divider. in_tready is high only while idle; a
//  result waits in the output register and only a second result stalls.
//  rst_n (synchronous) clears the sequencer, flags and slot state.
// ----------------------------------------------------------------------------
module gated_running_mean_variance
  import grmv_pkg::*;
#(
  parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT,
  parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // slot_index, sample_time, slot_time, slot_init_time, sample_value,
  // sample_status, sample_severity, severity_limit
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,  // cmd
  input  logic                  in_tlast,  // avg_done
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_slot, mean, variance, sample_count, read_count, last_time,
  // worst_status, worst_severity, same_time_count, missing_count, was_wiped
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data
);

  localparam int SLOT_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  grmv_state_t state_r, state_nxt;

  logic no_avg_r;
  logic out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // Slot state
  logic [63:0]           init_stamp_r [SLOT_COUNT];
  logic [63:0]           data_stamp_r [SLOT_COUNT];
  logic signed [31:0]    mean_r       [SLOT_COUNT];
  logic [63:0]           var_r        [SLOT_COUNT];
  logic [COUNT_BITS-1:0] cnt_r        [SLOT_COUNT];
  logic [31:0]           rdc_r        [SLOT_COUNT];
  logic [4:0]            mstat_r      [SLOT_COUNT];
  logic [1:0]            msev_r       [SLOT_COUNT];
  logic [31:0]           rep_r        [SLOT_COUNT];
  logic [26:0]           miss_r       [SLOT_COUNT];
  logic                  wiped_r      [SLOT_COUNT];

  // Item held during processing
  logic               cmd_r, done_r, ign_r;
  logic [3:0]         slot_r;
  logic [63:0]        t_r, init_r;
  logic signed [31:0] val_r;
  logic [4:0]         stat_r;
  logic [1:0]         sev_r, limit_r;

  // Arithmetic
  logic signed [32:0] d_r;
  logic [31:0]        absd_r;
  logic [63:0]        dq_r;
  logic [31:0]        rem_r;
  logic [31:0]        dvs_r;
  logic [63:0]        mc_r, acc_r;
  logic [31:0]        mp_r;
  logic [STEP_W-1:0]  step_r;

  logic [SLOT_BITS-1:0]  idx;
  logic                  slot_ok, go_w, same_w, gate_w, first_w, add_ok;
  logic                  div_last, mul_last, emit_fire;
  logic [COUNT_BITS-1:0] cnt_cur, cnt_inc;
  logic [32:0]           rem_sh;
  logic                  ge_w;
  logic signed [32:0]    d_w, d1_w;
  logic signed [33:0]    m_w;
  logic [32:0]           q_ext;
  logic [64:0]           vsum_w;
  logic [31:0]           cnt32;

  assign idx     = SLOT_BITS'(slot_r);
  assign slot_ok = {28'd0, slot_r} < 32'(SLOT_COUNT);
  assign cnt_cur = cnt_r[idx];
  assign cnt_inc = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
  assign go_w    = slot_ok && (cmd_r == CMD_CHECK ? data_stamp_r[idx] != t_r : !ign_r);
  assign same_w  = t_r == data_stamp_r[idx];
  assign gate_w  = sev_r < limit_r;
  assign first_w = (cnt_inc == COUNT_BITS'(1)) || no_avg_r;
  assign d_w     = 33'(val_r) - 33'(mean_r[idx]);

  // Shared restoring divider step.
  assign rem_sh = {rem_r, dq_r[63]};
  assign ge_w   = rem_sh >= {1'b0, dvs_r};

  assign q_ext = {1'b0, dq_r[31:0]};
  assign m_w   = 34'(mean_r[idx]) + (d_r[32] ? -34'(q_ext) : 34'(q_ext));
  assign d1_w  = 33'(val_r) - m_w[32:0];
  assign add_ok = (d_r[32] == d1_w[32]) || (d_r == '0) || (d1_w == '0);

  assign vsum_w = {1'b0, var_r[idx]} + {1'b0, acc_r};
  assign cnt32  = 32'(cnt_cur);

  assign div_last  = step_r == STEP_W'(DIV_STEPS - 1);
  assign mul_last  = step_r == STEP_W'(MUL_STEPS - 1);
  assign emit_fire = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = go_w ? ST_ACC : ST_IDLE;
      ST_ACC: begin
        if (same_w || !gate_w || first_w) state_nxt = ST_MISS;
        else state_nxt = ST_DIV_M;
      end
      ST_DIV_M: if (div_last) state_nxt = ST_MEAN;
      ST_MEAN:  state_nxt = add_ok ? ST_MUL : ST_MISS;
      ST_MUL:   if (mul_last) state_nxt = ST_VADD;
      ST_VADD:  state_nxt = ST_MISS;
      ST_MISS:  state_nxt = done_r ? ST_FIN : ST_IDLE;
      ST_FIN:   state_nxt = (cnt32 > 32'd1) ? ST_DIV_V : ST_EMIT;
      ST_DIV_V: if (div_last) state_nxt = ST_EMIT;
      ST_EMIT:  if (emit_fire) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = state_r == ST_IDLE;
    out_tvalid = out_valid_r;
    out_tdata  = out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      no_avg_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        init_stamp_r[i] <= '0;
        data_stamp_r[i] <= '0;
        mean_r[i]       <= '0;
        var_r[i]        <= '0;
        cnt_r[i]        <= '0;
        rdc_r[i]        <= '0;
        mstat_r[i]      <= '0;
        msev_r[i]       <= '0;
        rep_r[i]        <= '0;
        miss_r[i]       <= '0;
        wiped_r[i]      <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) no_avg_r <= cfg_wr_data;
      // In the emit state the valid flag is driven by the emit logic below.
      if (out_valid_r && out_tready && state_r != ST_EMIT) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            cmd_r   <= in_tuser;
            done_r  <= in_tlast;
            slot_r  <= in_tdata[3:0];
            init_r  <= in_tdata[195:132];
            limit_r <= in_tdata[236:235];
            ign_r   <= (in_tdata[67:4] != in_tdata[131:68]) || (in_tdata[67:4] == 64'd0);
            if (in_tuser == CMD_CHECK) begin
              t_r    <= in_tdata[131:68];
              val_r  <= '0;
              stat_r <= FILL_STATUS;
              sev_r  <= FILL_SEVERITY;
            end else begin
              t_r    <= in_tdata[67:4];
              val_r  <= in_tdata[227:196];
              stat_r <= in_tdata[232:228];
              sev_r  <= in_tdata[234:233];
            end
          end
        end
        ST_EVAL: begin
          if (go_w && init_r != init_stamp_r[idx]) begin
            init_stamp_r[idx] <= init_r;
            mean_r[idx]       <= '0;
            var_r[idx]        <= '0;
            cnt_r[idx]        <= '0;
            rdc_r[idx]        <= '0;
            wiped_r[idx]      <= 1'b1;
          end
        end
        ST_ACC: begin
          if (same_w) begin
            rep_r[idx] <= rep_r[idx] + 32'd1;
          end else begin
            data_stamp_r[idx] <= t_r;
            rdc_r[idx]        <= rdc_r[idx] + 32'd1;
            if (gate_w) begin
              if (first_w) begin
                cnt_r[idx]   <= COUNT_BITS'(1);
                mean_r[idx]  <= val_r;
                var_r[idx]   <= '0;
                mstat_r[idx] <= stat_r;
                msev_r[idx]  <= sev_r;
              end else begin
                cnt_r[idx] <= cnt_inc;
                d_r        <= d_w;
                absd_r     <= d_w[32] ? 32'(-d_w) : d_w[31:0];
                dq_r       <= {32'd0, d_w[32] ? 32'(-d_w) : d_w[31:0]};
                rem_r      <= '0;
                dvs_r      <= 32'(cnt_inc);
                step_r     <= '0;
                if (sev_r > msev_r[idx]) begin
                  msev_r[idx]  <= sev_r;
                  mstat_r[idx] <= stat_r;
                end
              end
            end
          end
        end
        ST_DIV_M, ST_DIV_V: begin
          dq_r   <= {dq_r[62:0], ge_w};
          rem_r  <= ge_w ? 32'(rem_sh - {1'b0, dvs_r}) : rem_sh[31:0];
          step_r <= step_r + 1'b1;
        end
        ST_MEAN: begin
          mean_r[idx] <= m_w[31:0];
          mc_r        <= {32'd0, absd_r};
          mp_r        <= d1_w[32] ? 32'(-d1_w) : d1_w[31:0];
          acc_r       <= '0;
          step_r      <= '0;
        end
        ST_MUL: begin
          if (mp_r[0]) acc_r <= acc_r + mc_r;
          mc_r   <= {mc_r[62:0], 1'b0};
          mp_r   <= {1'b0, mp_r[31:1]};
          step_r <= step_r + 1'b1;
        end
        ST_VADD: begin
          var_r[idx] <= vsum_w[64] ? '1 : vsum_w[63:0];
        end
        ST_MISS: begin
          if (cmd_r == CMD_CHECK)
            miss_r[idx] <= (miss_r[idx] < MISS_LIMIT) ? miss_r[idx] + 27'd1 : '0;
        end
        ST_FIN: begin
          if (cnt32 == 32'd0) begin
            mstat_r[idx] <= stat_r;
            msev_r[idx]  <= sev_r;
          end
          // With one sample or none the reported variance is zero, so the quotient
          // register is simply cleared.
          dq_r   <= (cnt32 > 32'd1) ? var_r[idx] : 64'd0;
          rem_r  <= '0;
          dvs_r  <= cnt32 - 32'd1;
          step_r <= '0;
        end
        ST_EMIT: begin
          if (emit_fire) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {6'd0, wiped_r[idx], miss_r[idx], rep_r[idx], msev_r[idx],
                            mstat_r[idx], data_stamp_r[idx], rdc_r[idx],
                            (cnt32 > 32'hFFFFF) ? 20'hFFFFF : cnt32[19:0],
                            dq_r[63] ? {63{1'b1}} : dq_r[62:0],
                            mean_r[idx], slot_r};
            cnt_r[idx]   <= '0;
            mean_r[idx]  <= '0;
            wiped_r[idx] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: sv/grmv_checker.sv
// ----------------------------------------------------------------------------
// grmv_checker
// Port-level checks on the gated running mean and variance block.
// ----------------------------------------------------------------------------
module grmv_checker
  import grmv_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // The sequencer is busy right after every transfer in.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // A result needs at least the evaluation cycles after an input transfer.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared right after input transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped without transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

endmodule

bind gated_running_mean_variance grmv_checker u_grmv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
